>>> rtl/swps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swps_pkg: shared types and constants of the sliding window path speed block
// Item layouts, derived widths, divider reciprocal and controller states.
// ----------------------------------------------------------------------------
package swps_pkg;

    localparam int COORD_W   = 24;
    localparam int WINDOW    = 15;
    localparam int RING_LEN  = WINDOW - 1;
    localparam int PTR_W     = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
    localparam int PS_W      = $clog2(WINDOW + 1);

    localparam int SQ_W      = 2 * COORD_W + 2;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int ROOT_CW   = $clog2(ROOT_W + 1);

    localparam int SQ_STEPS  = 4;
    localparam int SQ_CW     = $clog2(SQ_STEPS + 1);

    localparam int LEN_BITS  = $clog2(RING_LEN);
    localparam int SUM_W     = ROOT_W + LEN_BITS;
    localparam int DIV_SHIFT = SUM_W + LEN_BITS;
    localparam int RECIP_W   = SUM_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(RING_LEN) - 64'd1) / 64'(RING_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    localparam int MEAN_W    = 25;
    localparam int WNUM_W    = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
        logic                      restart;
    } in_item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_speed;
        logic [WNUM_W-1:0] window_number;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic first;
        logic clear;
        logic update;
    } win_ctrl_t;

    typedef struct packed {
        logic ps_zero;
        logic done;
        logic emit;
    } win_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_AVERAGE,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

>>> rtl/swps_sqsum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swps_sqsum: step vector sum of squares
// Holds the previous point, forms absolute coordinate differences and
// squares them one per cycle through a shared multiplier.
// ----------------------------------------------------------------------------
module swps_sqsum
    import swps_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire logic            start,
    input  wire in_item_t        point,
    output logic                 done,
    output logic [SQ_W-1:0]      sq_sum
);

    logic signed [COORD_W-1:0] prev_reg [3];
    logic [COORD_W-1:0]        diff_reg [3];
    logic [COORD_W-1:0]        diff_next [3];
    logic [2*COORD_W-1:0]      prod_reg;
    logic [SQ_W-1:0]           acc_reg;
    logic [SQ_CW-1:0]          cnt_reg;
    logic [SQ_CW-1:0]          cnt_next;
    logic                      done_reg;
    logic                      done_next;
    logic signed [COORD_W-1:0] cur [3];

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    assign cur[0] = point.x_coord;
    assign cur[1] = point.y_coord;
    assign cur[2] = point.z_coord;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff_next[i] = abs_diff(prev_reg[i], cur[i]);
        end
    end

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = SQ_CW'(SQ_STEPS);
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == SQ_CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            for (int i = 0; i < 3; i++) begin
                diff_reg[i] <= diff_next[i];
            end
            prod_reg <= '0;
            acc_reg  <= '0;
        end else if (cnt_reg != '0) begin
            prod_reg    <= diff_reg[0] * diff_reg[0];
            diff_reg[0] <= diff_reg[1];
            diff_reg[1] <= diff_reg[2];
            diff_reg[2] <= '0;
            acc_reg     <= acc_reg + SQ_W'(prod_reg);
        end
        if (load) begin
            for (int i = 0; i < 3; i++) begin
                prev_reg[i] <= cur[i];
            end
        end
    end

    assign done   = done_reg;
    assign sq_sum = acc_reg;

endmodule
`default_nettype wire

>>> rtl/swps_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swps_isqrt: digit serial integer square root
// Shifts the radicand in two bits per cycle and settles one root bit per
// cycle, giving the floored root.
// ----------------------------------------------------------------------------
module swps_isqrt
    import swps_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [SQ_W-1:0]   radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    logic [SQ_W-1:0]    rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [ROOT_CW-1:0] cnt_reg;
    logic [ROOT_CW-1:0] cnt_next;
    logic               done_reg;
    logic               done_next;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic               fits;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = ROOT_CW'(ROOT_W);
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == ROOT_CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

>>> rtl/swps_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swps_window: distance ring, running sum and mean
// Keeps the recent step distances with their sum, counts points and
// windows, and divides the sum by the ring length with a reciprocal.
// ----------------------------------------------------------------------------
module swps_window
    import swps_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire win_ctrl_t         ctrl,
    input  wire logic [ROOT_W-1:0] step_dist,
    output win_stat_t              stat,
    output out_item_t              result
);

    logic [ROOT_W-1:0]          ring_reg [RING_LEN];
    logic [PTR_W-1:0]           ptr_reg;
    logic [PTR_W-1:0]           ptr_next;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;
    logic [PS_W-1:0]            ps_reg;
    logic [PS_W-1:0]            ps_next;
    logic [WNUM_W-1:0]          wc_reg;
    logic [WNUM_W-1:0]          wc_next;
    logic                       emit_reg;
    logic                       emit_next;
    logic                       mul_vld_reg;
    logic                       done_reg;
    logic [SUM_W+RECIP_W-1:0]   prod_reg;
    logic                       full;
    logic [PS_W-1:0]            ps_inc;
    logic [SUM_W-1:0]           oldest;

    assign full   = (ps_reg == PS_W'(WINDOW));
    assign ps_inc = full ? ps_reg : ps_reg + 1'b1;
    assign oldest = full ? SUM_W'(ring_reg[ptr_reg]) : '0;

    always_comb begin
        ptr_next  = ptr_reg;
        sum_next  = sum_reg;
        ps_next   = ps_reg;
        wc_next   = wc_reg;
        emit_next = emit_reg;
        if (ctrl.load && ctrl.clear) begin
            ptr_next = '0;
            sum_next = '0;
            wc_next  = '0;
        end
        if (ctrl.load && ctrl.first) begin
            ps_next = PS_W'(1);
        end
        if (ctrl.update) begin
            sum_next  = sum_reg - oldest + SUM_W'(step_dist);
            ptr_next  = (ptr_reg == PTR_W'(RING_LEN - 1)) ? '0 : ptr_reg + 1'b1;
            ps_next   = ps_inc;
            emit_next = (ps_inc == PS_W'(WINDOW));
            if (ps_inc == PS_W'(WINDOW)) begin
                wc_next = wc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            sum_reg     <= '0;
            ps_reg      <= '0;
            wc_reg      <= '0;
            emit_reg    <= 1'b0;
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            ptr_reg     <= ptr_next;
            sum_reg     <= sum_next;
            ps_reg      <= ps_next;
            wc_reg      <= wc_next;
            emit_reg    <= emit_next;
            mul_vld_reg <= ctrl.update;
            done_reg    <= mul_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.update) begin
            ring_reg[ptr_reg] <= step_dist;
        end
        if (mul_vld_reg) begin
            prod_reg <= sum_reg * RECIP;
        end
    end

    assign stat.ps_zero         = (ps_reg == '0);
    assign stat.done            = done_reg;
    assign stat.emit            = emit_reg;
    assign result.mean_speed    = prod_reg[DIV_SHIFT +: MEAN_W];
    assign result.window_number = wc_reg;

endmodule
`default_nettype wire

>>> rtl/sliding_window_path_speed.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_path_speed: moving mean of euclidean step distance
// Streams 3d points, takes the distance between consecutive points and
// reports the mean of the recent distances once the window has filled.
//
//   channel   ports                       payload
//   input     s_valid s_ready s_data      in_item_t  (x, y, z, restart)
//   result    m_valid m_ready m_data      out_item_t (mean, window number)
//
// a point that starts a trajectory gives no result, and the next point can
// be taken in the cycle after it; any other point passes through the serial
// squares, the square root (a start and one root bit a cycle), the ring
// update, reciprocal multiply and hand-off, and the load of the result
// register. the next point is taken in the cycle after that load, or in the
// cycle after the average is done when the point gives no result. the root
// iteration sets the rate. reset clears all control state. a stalled result
// holds in the output register while the next point is taken; the block
// waits before loading a new result only while the old one is unaccepted.
// ----------------------------------------------------------------------------
module sliding_window_path_speed
    import swps_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    state_t            state_reg;
    state_t            state_next;
    logic              accept;
    logic              first;
    logic              sq_start;
    logic              sq_done;
    logic [SQ_W-1:0]   sq_sum;
    logic              root_done;
    logic [ROOT_W-1:0] root;
    win_ctrl_t         win_ctrl;
    win_stat_t         win_stat;
    out_item_t         win_result;
    logic              slot_free;
    logic              out_load;
    logic              m_valid_reg;
    logic              m_valid_next;
    out_item_t         m_data_reg;

    assign accept    = s_valid && s_ready;
    assign first     = s_data.restart || win_stat.ps_zero;
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && !first) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (sq_done) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_AVERAGE;
                end
            end
            ST_AVERAGE: begin
                if (win_stat.done) begin
                    state_next = win_stat.emit ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready         = (state_reg == ST_IDLE);
        out_load        = (state_reg == ST_EMIT) && slot_free;
        sq_start        = accept && !first;
        win_ctrl.load   = accept;
        win_ctrl.first  = first;
        win_ctrl.clear  = s_data.restart;
        win_ctrl.update = root_done;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= win_result;
        end
    end

    swps_sqsum u_sqsum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .start   (sq_start),
        .point   (s_data),
        .done    (sq_done),
        .sq_sum  (sq_sum)
    );

    swps_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_done),
        .radicand (sq_sum),
        .done     (root_done),
        .root     (root)
    );

    swps_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (win_ctrl),
        .step_dist (root),
        .stat      (win_stat),
        .result    (win_result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_root_in_root_state: assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> state_reg == ST_ROOT)
        else $error("root finished outside the root phase");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({sq_done, root_done, win_stat.done}))
        else $error("two arithmetic units finished together");

    a_emit_needs_history: assert property (@(posedge aclk) disable iff (!aresetn)
        win_stat.done && win_stat.emit |-> !win_stat.ps_zero)
        else $error("result raised with empty history");

    a_load_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !m_valid_reg || m_ready)
        else $error("result register overwritten before accept");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sliding_window_path_speed
// Sends 3d points through the valid/ready input, predicts the moving mean of
// the step distances and the window numbers, and compares every result item
// in order. Directed extremes and restarts come first. Random trajectories
// follow, mostly small random walks with some jumps, corners and restart
// bursts. The two sides idle in the first two of three phases, and one long
// result stall fills the block.
// ----------------------------------------------------------------------------
module testbench
    import swps_pkg::*;
();

    localparam int DIST_W        = 25;
    localparam int TOTAL_W       = 29;
    localparam int RANDOM_POINTS = 1150;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 600;
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    class path_speed_board;
        logic signed [COORD_W-1:0] last_x = '0;
        logic signed [COORD_W-1:0] last_y = '0;
        logic signed [COORD_W-1:0] last_z = '0;
        logic [DIST_W-1:0]         step_ring [RING_LEN];
        int unsigned               next_slot = 0;
        int unsigned               points = 0;
        logic [TOTAL_W-1:0]        step_total = '0;
        logic [WNUM_W-1:0]         windows_issued = '0;
        out_item_t                 pending [$];
        int                        errors = 0;

        function logic [63:0] abs_gap(logic signed [COORD_W-1:0] a,
                                      logic signed [COORD_W-1:0] b);
            longint gap;
            gap = longint'(a) - longint'(b);
            return (gap < 0) ? 64'(-gap) : 64'(gap);
        endfunction

        function logic [31:0] floor_root(logic [63:0] v);
            logic [31:0] root;
            logic [31:0] trial;
            root = '0;
            for (int i = 31; i >= 0; i--) begin
                trial = root | (32'd1 << i);
                if (64'(trial) * 64'(trial) <= v)
                    root = trial;
            end
            return root;
        endfunction

        function void note_point(in_item_t p);
            logic [63:0]       dx, dy, dz;
            logic [DIST_W-1:0] step;
            out_item_t         want;
            if (p.restart) begin
                next_slot      = 0;
                step_total     = '0;
                points         = 0;
                windows_issued = '0;
            end
            if (points == 0) begin
                last_x = p.x_coord;
                last_y = p.y_coord;
                last_z = p.z_coord;
                points = 1;
                return;
            end
            dx   = abs_gap(last_x, p.x_coord);
            dy   = abs_gap(last_y, p.y_coord);
            dz   = abs_gap(last_z, p.z_coord);
            step = DIST_W'(floor_root(dx * dx + dy * dy + dz * dz));
            last_x = p.x_coord;
            last_y = p.y_coord;
            last_z = p.z_coord;
            // oldest distance drops out once the window is full
            if (points >= WINDOW)
                step_total = step_total - TOTAL_W'(step_ring[next_slot]);
            step_ring[next_slot] = step;
            step_total = step_total + TOTAL_W'(step);
            next_slot  = (next_slot + 1) % RING_LEN;
            if (points < WINDOW)
                points++;
            if (points < WINDOW)
                return;
            windows_issued++;
            want.mean_speed    = MEAN_W'(step_total / TOTAL_W'(RING_LEN));
            want.window_number = windows_issued;
            pending.push_back(want);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                $error("unexpected item: mean_speed %0d window_number %0d",
                       got.mean_speed, got.window_number);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.mean_speed !== want.mean_speed) begin
                $error("mean_speed expected %0d actual %0d", want.mean_speed, got.mean_speed);
                errors++;
            end
            if (got.window_number !== want.window_number) begin
                $error("window_number expected %0d actual %0d",
                       want.window_number, got.window_number);
                errors++;
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    path_speed_board board = new;
    int        sink_idle_pct = 0;
    logic      pressure_req = 1'b0;
    logic      pressure_taken = 1'b0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    sliding_window_path_speed uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic in_item_t make_point(logic signed [COORD_W-1:0] x,
                                            logic signed [COORD_W-1:0] y,
                                            logic signed [COORD_W-1:0] z,
                                            logic restart);
        in_item_t p;
        p.x_coord = x;
        p.y_coord = y;
        p.z_coord = z;
        p.restart = restart;
        return p;
    endfunction

    function automatic logic signed [COORD_W-1:0] corner();
        case ($urandom_range(3))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] c);
        int unsigned       span;
        logic [COORD_W-1:0] step;
        span = $urandom_range(23);
        step = COORD_W'($urandom_range(0, 1 << span));
        return $urandom_range(1) ? c + step : c - step;
    endfunction

    function automatic in_item_t wander(in_item_t from, int restart_pct);
        in_item_t p;
        int       mode;
        mode = $urandom_range(99);
        if (mode < 8)
            p = make_point(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), 1'b0);
        else if (mode < 13)
            p = make_point(corner(), corner(), corner(), 1'b0);
        else
            p = make_point(nudge(from.x_coord), nudge(from.y_coord), nudge(from.z_coord), 1'b0);
        p.restart = ($urandom_range(99) < restart_pct);
        return p;
    endfunction

    task automatic send_point(in_item_t p, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        board.note_point(p);
    endtask

    // result side: check, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
        if (pressure_req && !pressure_taken) begin
            hold_left      = HOLD_CYCLES;
            pressure_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        in_item_t here;
        int       src_idle;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        sink_idle_pct <= 84;
        @(posedge aclk);

        // full-scale steps: largest distances, first windows
        for (int n = 0; n < 16; n++) begin
            here = (n % 2 == 1) ? make_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0)
                                : make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
            send_point(here, 25);
        end
        // restart on a full window, then on a lone point
        send_point(make_point('0, '0, '0, 1'b1), 25);
        send_point(make_point(COORD_MIN, COORD_MAX, '0, 1'b1), 25);
        send_point(make_point(COORD_W'(1), '0, '0, 1'b0), 25);
        send_point(make_point(COORD_W'(1), COORD_W'(1), '0, 1'b0), 25);
        here = make_point('1, '1, '1, 1'b0);
        send_point(here, 25);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle = 25;
                    sink_idle_pct <= 84;
                end
                1: begin
                    src_idle = 84;
                    sink_idle_pct <= 25;
                end
                default: begin
                    src_idle = 0;
                    sink_idle_pct <= 0;
                    pressure_req <= 1'b1;
                end
            endcase
            for (int n = 0; n < RANDOM_POINTS / 3; n++) begin
                here = wander(here, (n % 128 < 16) ? 35 : 2);
                send_point(here, src_idle);
            end
        end
        s_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
